### rtl/core/attack_decay_envelope_macros.svh
// Assertion macros shared by the envelope checker.
`ifndef ATTACK_DECAY_ENVELOPE_MACROS_SVH
`define ATTACK_DECAY_ENVELOPE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ADE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("envelope check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ADE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("envelope check failed");

`endif

### rtl/core/ade_pkg.sv
// Types, constants and helpers for the attack-decay envelope.
`timescale 1ns / 1ps

package ade_pkg;

  // Fixed-point layout: 1.0 is 2^FRAC_BITS
  localparam int FRAC_BITS = 24;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int COEFF_W   = 25;
  localparam int TARGET_W  = 28;
  localparam int PHASE_W   = 2;
  localparam int MAG_W     = TARGET_W;
  localparam int PROD_W    = COEFF_W + MAG_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TARGET_W + 3;

  // APB register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [LEVEL_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [COEFF_W-1:0]  ATTACK_COEFF_RST  = 25'd16125;
  localparam logic [COEFF_W-1:0]  DECAY_COEFF_RST   = 25'd3495;
  localparam logic [TARGET_W-1:0] ATTACK_TARGET_RST = 28'd16944988;
  localparam logic [LEVEL_W-1:0]  SUSTAIN_LEVEL_RST = 25'd8388608;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_ATTACK_COEFF  = 2'd0,
    REG_DECAY_COEFF   = 2'd1,
    REG_ATTACK_TARGET = 2'd2,
    REG_SUSTAIN_LEVEL = 2'd3
  } reg_idx_e;

  // Envelope state, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ATTACK = 4'b0010,
    PH_DECAY  = 4'b0100,
    PH_HOLD   = 4'b1000
  } phase_e;

  // Phase codes as seen on the result item
  localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ATTACK = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DECAY  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_HOLD   = 2'd3;

  typedef struct packed {
    logic trigger;
    logic hard_reset;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [COEFF_W-1:0]  attack_coeff;
    logic [COEFF_W-1:0]  decay_coeff;
    logic [TARGET_W-1:0] attack_target;
    logic [LEVEL_W-1:0]  sustain_level;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_e             phase;
  } env_state_t;

  // Saturate a Q1.24 quantity to 1.0
  function automatic logic [LEVEL_W-1:0] sat_one(input logic [LEVEL_W-1:0] v);
    return (v > ONE_FX) ? ONE_FX : v;
  endfunction

  // Map the internal state to its result code
  function automatic logic [PHASE_W-1:0] phase_code(input phase_e ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_ATTACK: code = PHASE_ATTACK;
      PH_DECAY:  code = PHASE_DECAY;
      PH_HOLD:   code = PHASE_HOLD;
      default:   code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/ade_cfg_regs.sv
// APB configuration registers of the attack-decay envelope.
`timescale 1ns / 1ps

module ade_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ade_pkg::ADDR_W-1:0] paddr,
  input  logic [ade_pkg::DATA_W-1:0] pwdata,
  output logic [ade_pkg::DATA_W-1:0] prdata,
  output ade_pkg::cfg_t              cfg_o
);

  ade_pkg::cfg_t     cfg_q;
  ade_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx   = ade_pkg::reg_idx_e'(paddr[ade_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff  <= ade_pkg::ATTACK_COEFF_RST;
      cfg_q.decay_coeff   <= ade_pkg::DECAY_COEFF_RST;
      cfg_q.attack_target <= ade_pkg::ATTACK_TARGET_RST;
      cfg_q.sustain_level <= ade_pkg::SUSTAIN_LEVEL_RST;
    end else if (wr_en) begin
      case (idx)
        ade_pkg::REG_ATTACK_COEFF:
          cfg_q.attack_coeff  <= pwdata[ade_pkg::COEFF_W-1:0];
        ade_pkg::REG_DECAY_COEFF:
          cfg_q.decay_coeff   <= pwdata[ade_pkg::COEFF_W-1:0];
        ade_pkg::REG_ATTACK_TARGET:
          cfg_q.attack_target <= pwdata[ade_pkg::TARGET_W-1:0];
        ade_pkg::REG_SUSTAIN_LEVEL:
          cfg_q.sustain_level <= pwdata[ade_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (idx)
      ade_pkg::REG_ATTACK_COEFF:
        prdata = {{(ade_pkg::DATA_W-ade_pkg::COEFF_W){1'b0}}, cfg_q.attack_coeff};
      ade_pkg::REG_DECAY_COEFF:
        prdata = {{(ade_pkg::DATA_W-ade_pkg::COEFF_W){1'b0}}, cfg_q.decay_coeff};
      ade_pkg::REG_ATTACK_TARGET:
        prdata = {{(ade_pkg::DATA_W-ade_pkg::TARGET_W){1'b0}}, cfg_q.attack_target};
      ade_pkg::REG_SUSTAIN_LEVEL:
        prdata = {{(ade_pkg::DATA_W-ade_pkg::LEVEL_W){1'b0}}, cfg_q.sustain_level};
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/ade_step.sv
// One envelope step: next state and result item from the current state and a tick.
`timescale 1ns / 1ps

module ade_step (
  input  ade_pkg::cfg_t       cfg_i,
  input  ade_pkg::env_state_t state_i,
  input  ade_pkg::in_item_t   item_i,
  output ade_pkg::env_state_t state_o,
  output ade_pkg::out_item_t  result_o
);

  localparam int SUM_W   = ade_pkg::SUM_W;
  localparam int LEVEL_W = ade_pkg::LEVEL_W;

  logic [LEVEL_W-1:0]             sus;
  ade_pkg::phase_e                eff_phase;
  logic [LEVEL_W-1:0]             eff_level;
  logic                           is_attack;
  logic [ade_pkg::COEFF_W-1:0]    coeff;
  logic signed [SUM_W-1:0]        level_s;
  logic signed [SUM_W-1:0]        one_s;
  logic signed [SUM_W-1:0]        sus_s;
  logic signed [SUM_W-1:0]        tgt_s;
  logic signed [SUM_W-1:0]        diff;
  logic signed [SUM_W-1:0]        diff_abs;
  logic                           diff_neg;
  logic [ade_pkg::MAG_W-1:0]      mag;
  logic [ade_pkg::PROD_W-1:0]     prod;
  logic [ade_pkg::SHIFT_W-1:0]    prod_sh;
  logic [ade_pkg::SHIFT_W-1:0]    step_mag;
  logic signed [SUM_W-1:0]        step_ext;
  logic signed [SUM_W-1:0]        step_s;
  logic signed [SUM_W-1:0]        nxt;
  logic [LEVEL_W-1:0]             nxt_clamp;
  logic                           over_one;

  // Apply the trigger ahead of the step
  assign sus       = ade_pkg::sat_one(cfg_i.sustain_level);
  assign eff_phase = item_i.trigger ? ade_pkg::PH_ATTACK : state_i.phase;
  assign eff_level = (item_i.trigger && item_i.hard_reset) ? '0 : state_i.level;
  assign is_attack = (eff_phase == ade_pkg::PH_ATTACK);

  assign level_s = $signed({{(SUM_W-LEVEL_W){1'b0}}, eff_level});
  assign one_s   = $signed({{(SUM_W-LEVEL_W){1'b0}}, ade_pkg::ONE_FX});
  assign sus_s   = $signed({{(SUM_W-LEVEL_W){1'b0}}, sus});
  assign tgt_s   = $signed({{(SUM_W-ade_pkg::TARGET_W){1'b0}}, cfg_i.attack_target});

  // Select coefficient and distance to target for the active phase
  assign coeff = is_attack ? ade_pkg::sat_one(cfg_i.attack_coeff)
                           : ade_pkg::sat_one(cfg_i.decay_coeff);
  assign diff     = is_attack ? (tgt_s - level_s) : (sus_s - level_s);
  assign diff_neg = diff[SUM_W-1];
  assign diff_abs = diff_neg ? -diff : diff;
  assign mag      = diff_abs[ade_pkg::MAG_W-1:0];

  // Scale, truncate toward zero, keep a step of at least one unless the distance is zero
  assign prod     = {{ade_pkg::MAG_W{1'b0}}, coeff} * {{ade_pkg::COEFF_W{1'b0}}, mag};
  assign prod_sh  = prod[ade_pkg::PROD_W-1:ade_pkg::FRAC_BITS];
  assign step_mag = (diff == '0) ? '0
                  : ((prod_sh == '0) ? ade_pkg::SHIFT_W'(1) : prod_sh);
  assign step_ext = $signed({{(SUM_W-ade_pkg::SHIFT_W){1'b0}}, step_mag});
  assign step_s   = diff_neg ? -step_ext : step_ext;
  assign nxt      = level_s + step_s;

  // Clamp to the range zero to one
  assign over_one  = (nxt > one_s);
  assign nxt_clamp = nxt[SUM_W-1] ? '0
                   : (over_one ? ade_pkg::ONE_FX : nxt[LEVEL_W-1:0]);

  // Advance the phase and pick the result
  always_comb begin
    state_o.level   = eff_level;
    state_o.phase   = eff_phase;
    result_o.level  = '0;
    case (eff_phase)
      ade_pkg::PH_ATTACK: begin
        state_o.level  = nxt_clamp;
        state_o.phase  = over_one ? ade_pkg::PH_DECAY : ade_pkg::PH_ATTACK;
        result_o.level = nxt_clamp;
      end
      ade_pkg::PH_DECAY: begin
        if (nxt_clamp <= sus) begin
          state_o.level  = sus;
          state_o.phase  = ade_pkg::PH_HOLD;
          result_o.level = sus;
        end else begin
          state_o.level  = nxt_clamp;
          result_o.level = nxt_clamp;
        end
      end
      ade_pkg::PH_HOLD: begin
        result_o.level = sus;
      end
      default: begin
        result_o.level = '0;
      end
    endcase
    result_o.phase = ade_pkg::phase_code(state_o.phase);
  end

endmodule

### rtl/core/attack_decay_envelope.sv
// Attack-decay-sustain envelope: one sample tick in, one level and phase out.
// Each item passes the input register, then the step logic, then the result register.
// One item per cycle while out_ready_i is high; the step is one multiply, add and clamp.
// The envelope state is updated as the item moves into the result register.
// Reset: level 0, phase idle, no items held, registers at their default values.
`timescale 1ns / 1ps

module attack_decay_envelope (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ade_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ade_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ade_pkg::ADDR_W-1:0] paddr,
  input  logic [ade_pkg::DATA_W-1:0] pwdata,
  output logic [ade_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  ade_pkg::cfg_t       cfg;
  logic                in_valid_q;
  ade_pkg::in_item_t   in_item_q;
  logic                out_valid_q;
  ade_pkg::out_item_t  out_item_q;
  ade_pkg::env_state_t state_q;
  ade_pkg::env_state_t state_d;
  ade_pkg::out_item_t  result_d;
  logic                in_accept;
  logic                advance;

  assign pready = 1'b1;

  ade_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  ade_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Move the held item on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
  end

  // Envelope state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.level <= '0;
      state_q.phase <= ade_pkg::PH_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

### rtl/core/ade_checker.sv
// Port-level checks for the attack-decay envelope, bound to the top level.
`timescale 1ns / 1ps
`include "attack_decay_envelope_macros.svh"

module ade_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ade_pkg::out_item_t out_data_o
);

  // A stalled result item holds
  `ADE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The level never passes 1.0
  `ADE_ASSERT_NOW(a_level_range, out_valid_o, out_data_o.level <= ade_pkg::ONE_FX)

  // Idle gives a zero level
  `ADE_ASSERT_NOW(a_idle_zero, out_valid_o && (out_data_o.phase == ade_pkg::PHASE_IDLE), out_data_o.level == '0)

  // Input stalls only behind a blocked result
  `ADE_ASSERT_NOW(a_in_stall, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind attack_decay_envelope ade_checker u_ade_checker (.*);
